/* design/coap_message_parser_assert.svh */
// ----------------------------------------------------------------------------
// CoAP message parser assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COAP_MESSAGE_PARSER_ASSERT_SVH
`define COAP_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define COAP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define COAP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/coap_pkg.sv */
// ----------------------------------------------------------------------------
// CoAP parser package
// Shared types, codes and sizes for the front, queue and back of the parser.
// ----------------------------------------------------------------------------
package coap_pkg;

	localparam logic [3:0] MAX_TOKEN_LEN = 4'd8;

	// depth of the queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_OPT_HEAD,
		PH_OPT_EXT,
		PH_OPT_VALUE,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		HS_NONE,
		HS_B0,
		HS_B1,
		HS_B2,
		HS_B3
	} hdr_sel_t;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_TOKEN   = 3'd1;
	localparam logic [2:0] KIND_OPTION  = 3'd2;
	localparam logic [2:0] KIND_VALUE   = 3'd3;
	localparam logic [2:0] KIND_MARKER  = 3'd4;
	localparam logic [2:0] KIND_PAYLOAD = 3'd5;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_VER    = 2'd1;
	localparam logic [1:0] ST_TOKEN_LONG = 2'd2;
	localparam logic [1:0] ST_TRUNC      = 2'd3;

	localparam logic [1:0] COAP_VERSION = 2'd1;
	localparam logic [7:0] PAYLOAD_MARK = 8'hFF;
	localparam logic [3:0] LEN_EXT      = 4'hF;
	localparam logic [8:0] LEN_EXT_BASE = 9'd15;

	// classified word handed from front to back
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic        last;
		hdr_sel_t    hdr_sel;
		logic [3:0]  delta;
		logic        len_load;
		logic [8:0]  len_val;
		logic [1:0]  status;
	} cls_t;

	// queue status towards the top level
	typedef struct packed {
		logic            full;
		logic            empty;
		logic [Q_AW:0]   count;
	} q_stat_t;

	// one result word
	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [7:0]  value_byte;
		logic [15:0] option_number;
		logic [8:0]  option_length;
		logic [1:0]  msg_type;
		logic [3:0]  token_length;
		logic [7:0]  msg_code;
		logic [15:0] message_id;
		logic [1:0]  status;
		logic        end_of_message;
	} res_t;

endpackage

/* design/coap_message_parser.sv */
// ----------------------------------------------------------------------------
// CoAP message parser
// Streaming byte labeller for CoAP-style messages with header field decode.
// ----------------------------------------------------------------------------
// Takes one word (a message byte plus its last-byte flag) per cycle while full
// is low and returns one result word per byte, in order, at one per cycle while
// pop is held high. The front phase machine classifies each byte into a four-word
// queue, and the back applies it to the header and option registers and writes a
// two-word result buffer, whose head is on the ports. Both sides stall on their
// own; full rises only when the queue holds four words.
// After the word that carries last_byte all parser state returns to reset, so
// the next byte starts a new header.
module coap_message_parser (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	// result queue side
	output logic [2:0]  byte_kind,
	output logic [7:0]  value_byte,
	output logic [15:0] option_number,
	output logic [8:0]  option_length,
	output logic [1:0]  msg_type,
	output logic [3:0]  token_length,
	output logic [7:0]  msg_code,
	output logic [15:0] message_id,
	output logic [1:0]  status,
	output logic        end_of_message,
	output logic        empty,
	input  logic        pop
);
	import coap_pkg::*;

	`include "coap_message_parser_assert.svh"

	cls_t    front_word;
	cls_t    q_word;
	q_stat_t q_stat;
	logic    take;
	logic    q_pop;
	res_t    res_word;

	// a pushed byte is taken whenever the queue has room
	assign full = q_stat.full;
	assign take = push && !q_stat.full;

	coap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.word      (front_word)
	);

	coap_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_word (front_word),
		.rd_en   (q_pop),
		.rd_word (q_word),
		.stat    (q_stat)
	);

	coap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res_word  (res_word)
	);

	// unpack the head result word
	assign byte_kind      = res_word.byte_kind;
	assign value_byte     = res_word.value_byte;
	assign option_number  = res_word.option_number;
	assign option_length  = res_word.option_length;
	assign msg_type       = res_word.msg_type;
	assign token_length   = res_word.token_length;
	assign msg_code       = res_word.msg_code;
	assign message_id     = res_word.message_id;
	assign status         = res_word.status;
	assign end_of_message = res_word.end_of_message;

	// error bytes always carry the header kind
	`COAP_ASSERT_NOW(a_err_kind, !empty && (status == ST_BAD_VER || status == ST_TOKEN_LONG), byte_kind == KIND_HEADER, "error word with non-header kind")
	// queue never holds more than its depth
	`COAP_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= (Q_AW+1)'(Q_DEPTH), "queue overfilled")
	// a byte taken into an empty queue is there the next cycle
	`COAP_ASSERT_NEXT(a_q_fill, take && q_stat.empty, !q_stat.empty, "taken byte lost from queue")
	// the back never reads an empty queue
	`COAP_ASSERT_NOW(a_q_pop, q_pop, !q_stat.empty, "pop of empty queue")

endmodule

/* design/coap_front.sv */
// ----------------------------------------------------------------------------
// CoAP parser front
// Phase machine: labels each byte and works out lengths, errors and status.
// ----------------------------------------------------------------------------
module coap_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output coap_pkg::cls_t word
);
	import coap_pkg::*;

	phase_t     phase_q, phase_d;
	logic [1:0] hidx_q, hidx_d;
	logic [3:0] tkl_q, tkl_d;
	logic [3:0] tok_left_q, tok_left_d;
	logic [8:0] val_left_q, val_left_d;
	logic [1:0] err_q, err_d;
	logic [8:0] ext_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hidx_q     <= '0;
			tkl_q      <= '0;
			tok_left_q <= '0;
			val_left_q <= '0;
			err_q      <= ST_OK;
		end else if (take) begin
			if (last_byte) begin
				phase_q    <= PH_HEADER;
				hidx_q     <= '0;
				tkl_q      <= '0;
				tok_left_q <= '0;
				val_left_q <= '0;
				err_q      <= ST_OK;
			end else begin
				phase_q    <= phase_d;
				hidx_q     <= hidx_d;
				tkl_q      <= tkl_d;
				tok_left_q <= tok_left_d;
				val_left_q <= val_left_d;
				err_q      <= err_d;
			end
		end
	end

	assign ext_len = LEN_EXT_BASE + {1'b0, data_byte};

	always_comb begin
		phase_d       = phase_q;
		hidx_d        = hidx_q;
		tkl_d         = tkl_q;
		tok_left_d    = tok_left_q;
		val_left_d    = val_left_q;
		err_d         = err_q;
		word.kind     = KIND_HEADER;
		word.data     = data_byte;
		word.last     = last_byte;
		word.hdr_sel  = HS_NONE;
		word.delta    = '0;
		word.len_load = 1'b0;
		word.len_val  = '0;

		unique case (phase_q)
			PH_HEADER: begin
				hidx_d = hidx_q + 2'd1;
				unique case (hidx_q)
					2'd0: begin
						word.hdr_sel = HS_B0;
						tkl_d        = data_byte[3:0];
						if (data_byte[7:6] != COAP_VERSION) begin
							err_d   = ST_BAD_VER;
							phase_d = PH_ERROR;
						end
					end
					2'd1: word.hdr_sel = HS_B1;
					2'd2: word.hdr_sel = HS_B2;
					default: begin
						word.hdr_sel = HS_B3;
						priority if (tkl_q > MAX_TOKEN_LEN) begin
							err_d   = ST_TOKEN_LONG;
							phase_d = PH_ERROR;
						end else if (tkl_q != 4'd0) begin
							tok_left_d = tkl_q;
							phase_d    = PH_TOKEN;
						end else begin
							phase_d = PH_OPT_HEAD;
						end
					end
				endcase
			end
			PH_TOKEN: begin
				word.kind  = KIND_TOKEN;
				tok_left_d = tok_left_q - 4'd1;
				if (tok_left_d == 4'd0) phase_d = PH_OPT_HEAD;
			end
			PH_OPT_HEAD: begin
				if (data_byte == PAYLOAD_MARK) begin
					word.kind = KIND_MARKER;
					phase_d   = PH_PAYLOAD;
				end else begin
					word.kind     = KIND_OPTION;
					word.delta    = data_byte[7:4];
					word.len_load = 1'b1;
					if (data_byte[3:0] == LEN_EXT) begin
						word.len_val = LEN_EXT_BASE;
						val_left_d   = '0;
						phase_d      = PH_OPT_EXT;
					end else begin
						word.len_val = {5'd0, data_byte[3:0]};
						val_left_d   = {5'd0, data_byte[3:0]};
						phase_d      = (data_byte[3:0] != 4'd0) ? PH_OPT_VALUE : PH_OPT_HEAD;
					end
				end
			end
			PH_OPT_EXT: begin
				word.kind     = KIND_OPTION;
				word.len_load = 1'b1;
				word.len_val  = ext_len;
				val_left_d    = ext_len;
				phase_d       = (ext_len != 9'd0) ? PH_OPT_VALUE : PH_OPT_HEAD;
			end
			PH_OPT_VALUE: begin
				word.kind  = KIND_VALUE;
				val_left_d = val_left_q - 9'd1;
				if (val_left_d == 9'd0) phase_d = PH_OPT_HEAD;
			end
			PH_PAYLOAD: word.kind = KIND_PAYLOAD;
			default: begin
				word.kind = KIND_HEADER;
				phase_d   = PH_ERROR;
			end
		endcase

		// truncation only where no error is already flagged
		word.status = err_d;
		if (last_byte && (err_d == ST_OK) &&
			(phase_d == PH_HEADER || phase_d == PH_TOKEN ||
			 phase_d == PH_OPT_EXT || phase_d == PH_OPT_VALUE)) begin
			word.status = ST_TRUNC;
		end
	end

endmodule

/* design/coap_queue.sv */
// ----------------------------------------------------------------------------
// CoAP parser queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module coap_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  coap_pkg::cls_t    wr_word,
	input  logic              rd_en,
	output coap_pkg::cls_t    rd_word,
	output coap_pkg::q_stat_t stat
);
	import coap_pkg::*;

	cls_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

	assign do_wr   = wr_en && !stat.full;
	assign do_rd   = rd_en && !stat.empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/coap_back.sv */
// ----------------------------------------------------------------------------
// CoAP parser back
// Holds header fields and option number, builds results into a two-word buffer.
// ----------------------------------------------------------------------------
module coap_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  coap_pkg::cls_t q_word,
	output logic           q_pop,
	input  logic           res_pop,
	output logic           res_empty,
	output coap_pkg::res_t res_word
);
	import coap_pkg::*;

	logic [1:0]  typ_q, typ_d;
	logic [3:0]  tkl_q, tkl_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] mid_q, mid_d;
	logic [15:0] run_q, run_d;
	logic [8:0]  len_q, len_d;

	res_t        buf0_q, buf1_q, res_new;
	logic [1:0]  cnt_q;
	logic        do_out;

	assign q_pop     = !q_empty && (cnt_q != 2'd2);
	assign res_empty = (cnt_q == 2'd0);
	assign do_out    = res_pop && !res_empty;
	assign res_word  = buf0_q;

	always_comb begin
		typ_d  = typ_q;
		tkl_d  = tkl_q;
		code_d = code_q;
		mid_d  = mid_q;
		unique case (q_word.hdr_sel)
			HS_B0: begin
				typ_d = q_word.data[5:4];
				tkl_d = q_word.data[3:0];
			end
			HS_B1:   code_d = q_word.data;
			HS_B2:   mid_d  = {mid_q[15:8], q_word.data};
			HS_B3:   mid_d  = {q_word.data, mid_q[7:0]};
			default: ;
		endcase
		run_d = run_q + {12'd0, q_word.delta};
		len_d = q_word.len_load ? q_word.len_val : len_q;

		res_new.byte_kind      = q_word.kind;
		res_new.value_byte     = q_word.data;
		res_new.option_number  = run_d;
		res_new.option_length  = len_d;
		res_new.msg_type       = typ_d;
		res_new.token_length   = tkl_d;
		res_new.msg_code       = code_d;
		res_new.message_id     = mid_d;
		res_new.status         = q_word.status;
		res_new.end_of_message = q_word.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			typ_q  <= '0;
			tkl_q  <= '0;
			code_q <= '0;
			mid_q  <= '0;
			run_q  <= '0;
			len_q  <= '0;
		end else if (q_pop) begin
			if (q_word.last) begin
				typ_q  <= '0;
				tkl_q  <= '0;
				code_q <= '0;
				mid_q  <= '0;
				run_q  <= '0;
				len_q  <= '0;
			end else begin
				typ_q  <= typ_d;
				tkl_q  <= tkl_d;
				code_q <= code_d;
				mid_q  <= mid_d;
				run_q  <= run_d;
				len_q  <= len_d;
			end
		end
	end

	// result buffer: buf0 is the head
	always_ff @(posedge clk) begin
		unique case ({q_pop, do_out})
			2'b10: begin
				if (cnt_q == 2'd0) buf0_q <= res_new;
				else buf1_q <= res_new;
			end
			2'b01: buf0_q <= buf1_q;
			2'b11: begin
				if (cnt_q == 2'd1) buf0_q <= res_new;
				else begin
					buf0_q <= buf1_q;
					buf1_q <= res_new;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({q_pop, do_out})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* tb/tb_coap_message_parser.sv */
// ----------------------------------------------------------------------------
// CoAP message parser testbench
// Streams whole and damaged messages through the parser and checks every
// labelled word against an in-bench copy of the parse state machine. Sender
// gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coap_message_parser;

	import coap_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int WORDS_PER_PHASE = 310;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_word_t;

	typedef enum int {
		MSG_GOOD,
		MSG_CUT,
		MSG_BAD_VER,
		MSG_LONG_TOKEN,
		MSG_NOISE
	} msg_shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic [2:0]  byte_kind;
	logic [7:0]  value_byte;
	logic [15:0] option_number;
	logic [8:0]  option_length;
	logic [1:0]  msg_type;
	logic [3:0]  token_length;
	logic [7:0]  msg_code;
	logic [15:0] message_id;
	logic [1:0]  status;
	logic        end_of_message;
	logic        empty;

	coap_message_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.push           (push),
		.full           (full),
		.byte_kind      (byte_kind),
		.value_byte     (value_byte),
		.option_number  (option_number),
		.option_length  (option_length),
		.msg_type       (msg_type),
		.token_length   (token_length),
		.msg_code       (msg_code),
		.message_id     (message_id),
		.status         (status),
		.end_of_message (end_of_message),
		.empty          (empty),
		.pop            (pop)
	);

	always #1 clk = ~clk;

	in_word_t outgoing_words[$];
	res_t     expected_labels[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit in_fire = 1'b0;
	int errors = 0;
	int words_queued = 0;
	int messages_queued = 0;
	int results_checked = 0;
	int ending_status[4];

	// parse state mirrored from the block
	phase_t      msg_phase;
	logic [1:0]  hdr_idx;
	logic [1:0]  hdr_type;
	logic [3:0]  hdr_tkl;
	logic [7:0]  hdr_code;
	logic [15:0] hdr_mid;
	logic [3:0]  tok_left;
	logic [15:0] opt_num;
	logic [8:0]  val_left;
	logic [8:0]  opt_len;
	logic [1:0]  msg_err;

	task automatic clear_parse_state();
		msg_phase = PH_HEADER;
		hdr_idx   = '0;
		hdr_type  = '0;
		hdr_tkl   = '0;
		hdr_code  = '0;
		hdr_mid   = '0;
		tok_left  = '0;
		opt_num   = '0;
		val_left  = '0;
		opt_len   = '0;
		msg_err   = ST_OK;
	endtask

	task automatic open_value(input logic [8:0] len);
		opt_len   = len;
		val_left  = len;
		msg_phase = (len != 0) ? PH_OPT_VALUE : PH_OPT_HEAD;
	endtask

	// label one byte and advance the parse state
	task automatic label_byte(input logic [7:0] b, input logic lst, output res_t r);
		logic [2:0] kind;
		logic [1:0] st;
		kind = KIND_HEADER;
		case (msg_phase)
			PH_HEADER: begin
				case (hdr_idx)
					2'd0: begin
						hdr_type = b[5:4];
						hdr_tkl  = b[3:0];
						if (b[7:6] != COAP_VERSION) begin
							msg_err   = ST_BAD_VER;
							msg_phase = PH_ERROR;
						end
					end
					2'd1: hdr_code = b;
					2'd2: hdr_mid[7:0] = b;
					default: begin
						hdr_mid[15:8] = b;
						if (hdr_tkl > MAX_TOKEN_LEN) begin
							msg_err   = ST_TOKEN_LONG;
							msg_phase = PH_ERROR;
						end else if (hdr_tkl != 0) begin
							tok_left  = hdr_tkl;
							msg_phase = PH_TOKEN;
						end else begin
							msg_phase = PH_OPT_HEAD;
						end
					end
				endcase
				hdr_idx = hdr_idx + 2'd1;
			end
			PH_TOKEN: begin
				kind = KIND_TOKEN;
				tok_left = tok_left - 4'd1;
				if (tok_left == 0)
					msg_phase = PH_OPT_HEAD;
			end
			PH_OPT_HEAD: begin
				if (b == PAYLOAD_MARK) begin
					kind = KIND_MARKER;
					msg_phase = PH_PAYLOAD;
				end else begin
					kind = KIND_OPTION;
					opt_num = opt_num + {12'd0, b[7:4]};
					if (b[3:0] == LEN_EXT) begin
						opt_len   = LEN_EXT_BASE;
						val_left  = '0;
						msg_phase = PH_OPT_EXT;
					end else begin
						open_value({5'd0, b[3:0]});
					end
				end
			end
			PH_OPT_EXT: begin
				kind = KIND_OPTION;
				open_value(LEN_EXT_BASE + {1'b0, b});
			end
			PH_OPT_VALUE: begin
				kind = KIND_VALUE;
				val_left = val_left - 9'd1;
				if (val_left == 0)
					msg_phase = PH_OPT_HEAD;
			end
			PH_PAYLOAD: kind = KIND_PAYLOAD;
			default: msg_phase = PH_ERROR;
		endcase

		// ending mid-field counts as truncated unless an error came first
		st = msg_err;
		if (lst && st == ST_OK && (msg_phase == PH_HEADER || msg_phase == PH_TOKEN ||
				msg_phase == PH_OPT_EXT || msg_phase == PH_OPT_VALUE))
			st = ST_TRUNC;

		r = {kind, b, opt_num, opt_len, hdr_type, hdr_tkl, hdr_code, hdr_mid, st, lst};
		if (lst)
			clear_parse_state();
	endtask

	task automatic queue_word(input logic [7:0] b, input logic lst);
		outgoing_words.push_back('{data: b, last: lst});
		words_queued++;
		if (lst)
			messages_queued++;
	endtask

	// build one message of the given shape and queue it
	task automatic queue_message(input msg_shape_t shape);
		logic [7:0] msg[$];
		logic [3:0] tkl;
		logic [1:0] ver;
		logic [3:0] len_nib;
		logic [7:0] ext;
		int n_opt;
		int n_val;
		int cut;
		ver = COAP_VERSION;
		tkl = 4'($urandom_range(MAX_TOKEN_LEN));
		if (shape == MSG_BAD_VER) begin
			ver = 2'($urandom_range(2));
			if (ver != 0)
				ver = ver + 2'd1;
		end
		if (shape == MSG_LONG_TOKEN)
			tkl = 4'($urandom_range(15, MAX_TOKEN_LEN + 1));
		if (shape == MSG_NOISE) begin
			repeat ($urandom_range(12, 1))
				msg.push_back(8'($urandom_range(255)));
		end else begin
			msg.push_back({ver, 2'($urandom_range(3)), tkl});
			repeat (3)
				msg.push_back(8'($urandom_range(255)));
			repeat (tkl)
				msg.push_back(8'($urandom_range(255)));
			n_opt = $urandom_range(4);
			repeat (n_opt) begin
				len_nib = ($urandom_range(5) == 0) ? LEN_EXT : 4'($urandom_range(6));
				msg.push_back({4'($urandom_range(15)), len_nib});
				n_val = int'(len_nib);
				if (len_nib == LEN_EXT) begin
					// mostly short extensions, now and then one of any size
					ext = ($urandom_range(15) == 0) ? 8'($urandom_range(255))
						: 8'($urandom_range(4));
					msg.push_back(ext);
					n_val = int'(LEN_EXT_BASE) + int'(ext);
				end
				repeat (n_val)
					msg.push_back(8'($urandom_range(255)));
			end
			if ($urandom_range(1)) begin
				msg.push_back(PAYLOAD_MARK);
				repeat ($urandom_range(6))
					msg.push_back(8'($urandom_range(255)));
			end
		end
		cut = msg.size();
		if (shape == MSG_CUT)
			cut = $urandom_range(msg.size() - 1, 1);
		for (int i = 0; i < cut; i++)
			queue_word(msg[i], i == cut - 1);
	endtask

	task automatic flag_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (errors < MAX_REPORTS)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		errors++;
	endtask

	// driver: words change on the falling edge, held until taken
	always @(negedge clk) begin : drive_words
		in_word_t nxt;
		if (arst_n) begin
			if (!push || in_fire) begin
				if (outgoing_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = outgoing_words.pop_front();
					data_byte <= nxt.data;
					last_byte <= nxt.last;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on each accepted byte, check on each accepted result
	always @(posedge clk) begin : watch_words
		res_t want;
		res_t seen;
		if (arst_n) begin
			in_fire = push && !full;
			if (in_fire) begin
				label_byte(data_byte, last_byte, want);
				expected_labels.push_back(want);
				if (last_byte)
					ending_status[want.status]++;
			end
			if (pop && !empty) begin
				seen = {byte_kind, value_byte, option_number, option_length, msg_type,
					token_length, msg_code, message_id, status, end_of_message};
				if (expected_labels.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected result word, got 0x%0h", $time, seen);
					errors++;
				end else begin
					want = expected_labels.pop_front();
					results_checked++;
					if (seen.byte_kind !== want.byte_kind)
						flag_field("byte_kind", 16'(want.byte_kind), 16'(seen.byte_kind));
					if (seen.value_byte !== want.value_byte)
						flag_field("value_byte", 16'(want.value_byte),
							16'(seen.value_byte));
					if (seen.option_number !== want.option_number)
						flag_field("option_number", want.option_number, seen.option_number);
					if (seen.option_length !== want.option_length)
						flag_field("option_length", 16'(want.option_length),
							16'(seen.option_length));
					if (seen.msg_type !== want.msg_type)
						flag_field("msg_type", 16'(want.msg_type), 16'(seen.msg_type));
					if (seen.token_length !== want.token_length)
						flag_field("token_length", 16'(want.token_length),
							16'(seen.token_length));
					if (seen.msg_code !== want.msg_code)
						flag_field("msg_code", 16'(want.msg_code), 16'(seen.msg_code));
					if (seen.message_id !== want.message_id)
						flag_field("message_id", want.message_id, seen.message_id);
					if (seen.status !== want.status)
						flag_field("status", 16'(want.status), 16'(seen.status));
					if (seen.end_of_message !== want.end_of_message)
						flag_field("end_of_message", 16'(want.end_of_message),
							16'(seen.end_of_message));
				end
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin : watchdog
		int quiet;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, quiet, expected_labels.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_start;
		int pick;
		clear_parse_state();
		foreach (ending_status[i])
			ending_status[i] = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			phase_start = words_queued;
			if (ph == 0) begin
				// header only, message id 0x1234 with its low byte first
				queue_word(8'h40, 1'b0); queue_word(8'h00, 1'b0);
				queue_word(8'h34, 1'b0); queue_word(8'h12, 1'b1);
				// bad version, then one error byte
				queue_word(8'hC0, 1'b0); queue_word(8'h55, 1'b1);
				// token length 15, flagged on the final header byte
				queue_word(8'h6F, 1'b0); queue_word(8'h01, 1'b0);
				queue_word(8'h02, 1'b0); queue_word(8'h03, 1'b1);
				// type 3, one token, zero-length and two-byte options, payload
				queue_word(8'h71, 1'b0); queue_word(8'hFF, 1'b0);
				queue_word(8'h00, 1'b0); queue_word(8'hFF, 1'b0);
				queue_word(8'hAB, 1'b0); queue_word(8'hF0, 1'b0);
				queue_word(8'h12, 1'b0); queue_word(8'h80, 1'b0);
				queue_word(8'h7F, 1'b0); queue_word(PAYLOAD_MARK, 1'b0);
				queue_word(8'h00, 1'b1);
				// ends while the length extension is still owed
				queue_word(8'h40, 1'b0); queue_word(8'h00, 1'b0);
				queue_word(8'h00, 1'b0); queue_word(8'h00, 1'b0);
				queue_word(8'h1F, 1'b1);
			end
			while (words_queued - phase_start < WORDS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 70)
					queue_message(MSG_GOOD);
				else if (pick < 80)
					queue_message(MSG_CUT);
				else if (pick < 87)
					queue_message(MSG_BAD_VER);
				else if (pick < 94)
					queue_message(MSG_LONG_TOKEN);
				else
					queue_message(MSG_NOISE);
			end
			while (outgoing_words.size() != 0 || push || expected_labels.size() != 0)
				@(negedge clk);
		end

		// a short tail catches any stray result word
		repeat (10) @(negedge clk);
		if (expected_labels.size() != 0)
			errors++;

		$display("Parsed %0d words in %0d messages; %0d results checked, %0d mismatches.",
			words_queued, messages_queued, results_checked, errors);
		$display("Endings: %0d ok, %0d bad version, %0d token too long, %0d truncated.",
			ending_status[ST_OK], ending_status[ST_BAD_VER],
			ending_status[ST_TOKEN_LONG], ending_status[ST_TRUNC]);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/coap_pkg.sv
design/coap_front.sv
design/coap_queue.sv
design/coap_back.sv
design/coap_message_parser.sv
tb/tb_coap_message_parser.sv
